// ===== rtl/bba_pkg.sv =====
// Package for the bitmap block allocator.
// Holds the shared defaults, operation codes, state type and the cell control struct.
// No dependencies.
package bba_pkg;

    localparam int NUM_BLOCKS_DEF      = 256;
    localparam int RESERVED_BLOCKS_DEF = 22;

    // operation codes of the func field
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // control broadcast to every cell of the map chain
    typedef struct packed {
        logic shift;    // rotate the map one place toward cell 0
        logic wr_en;    // write one entry this cycle
        logic wr_data;  // value written: 1 used, 0 free
    } t_chain_ctrl;

endpackage

// ===== rtl/bba_cell.sv =====
// One map cell of the block allocator: holds one allocation bit.
// Depends on bba_pkg (t_chain_ctrl).
module bba_cell
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_init,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_sel,
    input  logic        i_next,
    output logic        o_bit
);

    logic r_bit;

    // shift takes the neighbor's bit; otherwise a selected write lands here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= i_init;
        end else if (i_ctrl.shift) begin
            r_bit <= i_next;
        end else if (i_ctrl.wr_en && i_sel) begin
            r_bit <= i_ctrl.wr_data;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== rtl/bba_chain.sv =====
// Ring of allocation-map cells; cell 0 is the scan head.
// Depends on bba_pkg and bba_cell.
module bba_chain
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF,
    localparam int IW             = $clog2(NUM_BLOCKS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_chain_ctrl   i_ctrl,
    input  logic [IW-1:0] i_wr_index,
    output logic          o_head,
    output logic          o_wr_old
);

    logic [NUM_BLOCKS-1:0] bits;
    logic [NUM_BLOCKS-1:0] sel;

    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        localparam int NXT = (k + 1) % NUM_BLOCKS;

        assign sel[k] = (i_wr_index == IW'(k));

        bba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  ((k < RESERVED_BLOCKS) ? 1'b1 : 1'b0),
            .i_ctrl  (i_ctrl),
            .i_sel   (sel[k]),
            .i_next  (bits[NXT]),
            .o_bit   (bits[k])
        );
    end

    assign o_head   = bits[0];
    assign o_wr_old = |(sel & bits);

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// Top level of the bitmap block allocator: command FSM, free counter, scan logic.
// Depends on bba_pkg and bba_chain.
//
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. i_func selects a map write (i_block_index, i_mark_used) or an
//   allocation request (i_blocks_needed, i_contiguous).
//   Result channel: o_done is high for exactly one cycle with o_granted,
//   o_first_block and o_free_count. The receiver cannot stall; each result
//   beat is taken at the edge that ends its cycle.
//   Result timing:
//     map write, or a request for zero blocks or for more than the free
//     count: result in the cycle after the command beat; busy stays low.
//     request that scans: the map rotates once around the cell ring past the
//     head cell, one entry per cycle, and the result is registered after the
//     last rotation, so the scan length grows with NUM_BLOCKS.
//   busy is high during the scan; a new command can be given in the cycle that
//   carries o_done.
//   Reset (synchronous, active low): the first RESERVED_BLOCKS map entries are
//   marked used, the rest free; the free count is reloaded; no result pending.
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
    parameter int RESERVED_BLOCKS = RESERVED_BLOCKS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_func,
    input  logic [7:0] i_block_index,
    input  logic       i_mark_used,
    input  logic [8:0] i_blocks_needed,
    input  logic       i_contiguous,
    output logic       o_done,
    output logic       o_granted,
    output logic [7:0] o_first_block,
    output logic [8:0] o_free_count
);

    localparam int IW    = $clog2(NUM_BLOCKS);
    localparam int FW    = $clog2(NUM_BLOCKS + 1);
    localparam int CW    = (FW > 9) ? FW : 9;
    localparam int SW    = (IW > 8) ? IW : 8;
    localparam int RES   = (RESERVED_BLOCKS < NUM_BLOCKS) ? RESERVED_BLOCKS : NUM_BLOCKS;
    localparam int FREE0 = NUM_BLOCKS - RES;

    t_state      r_state, n_state;
    logic [FW-1:0] r_free, n_free;
    logic [FW-1:0] r_run, n_run;
    logic [IW-1:0] r_step, n_step;
    logic [8:0]  r_target, n_target;
    logic        r_found, n_found;
    logic [7:0]  r_start, n_start;
    logic        r_done, n_done;
    logic        r_granted, n_granted;
    logic [7:0]  r_first, n_first;

    t_chain_ctrl ctrl;
    logic        head;
    logic        wr_old;
    logic        idx_ok;
    logic        hit;
    logic [SW-1:0] step_w;
    logic [7:0]  hit_start;
    logic [FW-1:0] run_next;

    bba_chain #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_wr_index (IW'(i_block_index)),
        .o_head     (head),
        .o_wr_old   (wr_old)
    );

    assign idx_ok = (32'(i_block_index) < 32'(NUM_BLOCKS));

    // run length ending at the entry now under the head; start kept mod 256
    assign run_next  = head ? '0 : (r_run + FW'(1));
    assign hit       = !r_found && (CW'(run_next) == CW'(r_target));
    assign step_w    = SW'(r_step);
    assign hit_start = step_w[7:0] + 8'd1 - r_target[7:0];

    always_comb begin
        n_state   = r_state;
        n_free    = r_free;
        n_run     = r_run;
        n_step    = r_step;
        n_target  = r_target;
        n_found   = r_found;
        n_start   = r_start;
        n_done    = 1'b0;
        n_granted = 1'b0;
        n_first   = 8'd0;
        ctrl      = '0;
        ctrl.wr_data = i_mark_used;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_WRITE) begin
                        ctrl.wr_en = idx_ok;
                        if (idx_ok && (wr_old != i_mark_used)) begin
                            n_free = i_mark_used ? (r_free - FW'(1)) : (r_free + FW'(1));
                        end
                        n_done = 1'b1;
                    end else if ((i_blocks_needed == 9'd0) ||
                                 (CW'(r_free) < CW'(i_blocks_needed))) begin
                        n_done = 1'b1;
                    end else begin
                        // chained mode is a first-fit search for a run of one
                        n_target = i_contiguous ? i_blocks_needed : 9'd1;
                        n_run    = '0;
                        n_step   = '0;
                        n_found  = 1'b0;
                        n_start  = 8'd0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                ctrl.shift = 1'b1;
                n_run      = run_next;
                n_step     = r_step + IW'(1);
                if (hit) begin
                    n_found = 1'b1;
                    n_start = hit_start;
                end
                // last rotation puts the map back in place
                if (r_step == IW'(NUM_BLOCKS - 1)) begin
                    n_state   = ST_IDLE;
                    n_done    = 1'b1;
                    n_granted = r_found || hit;
                    n_first   = r_found ? r_start : (hit ? hit_start : 8'd0);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_free    <= FW'(FREE0);
            r_done    <= 1'b0;
            r_granted <= 1'b0;
            r_first   <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_done    <= n_done;
            r_granted <= n_granted;
            r_first   <= n_first;
        end
    end

    // scan payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_run    <= n_run;
        r_step   <= n_step;
        r_target <= n_target;
        r_found  <= n_found;
        r_start  <= n_start;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_granted     = r_granted;
    assign o_first_block = r_first;
    assign o_free_count  = 9'(r_free);

    // result beat only once the scan has finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while scan still running");

    // a grant never appears without its strobe
    a_grant_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_granted |-> o_done)
        else $error("grant flag without result strobe");

    // free count stays within the map size
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= 32'(NUM_BLOCKS))
        else $error("free count out of range");

    // a map write answers in the next cycle
    a_write_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_WRITE)) |=> (o_done && !o_granted && !busy))
        else $error("map write result late or wrong");

endmodule
